// ===== rtl/mrs_pkg.sv =====
// Shared types and constants of the Modbus RTU slave engine.
package mrs_pkg;

  localparam int RX_DEPTH_DEF      = 256;
  localparam int COIL_DEPTH_DEF    = 512;
  localparam int HOLDING_DEPTH_DEF = 512;
  localparam int INPUT_DEPTH_DEF   = 512;

  // index field of a queue entry covers the largest receive buffer (512)
  localparam int QE_IDX_W = 10;
  localparam int Q_DEPTH  = 4;

  localparam logic [1:0] CMD_BYTE  = 2'd0;
  localparam logic [1:0] CMD_TICK  = 2'd1;
  localparam logic [1:0] CMD_LOCAL = 2'd2;

  localparam logic [7:0] FC_READ_COILS    = 8'd1;
  localparam logic [7:0] FC_READ_DISCRETE = 8'd2;
  localparam logic [7:0] FC_READ_HOLDING  = 8'd3;
  localparam logic [7:0] FC_READ_INPUT    = 8'd4;
  localparam logic [7:0] FC_WRITE_COIL    = 8'd5;
  localparam logic [7:0] FC_WRITE_REG     = 8'd6;
  localparam logic [7:0] FC_WRITE_COILS   = 8'd15;
  localparam logic [7:0] FC_WRITE_REGS    = 8'd16;

  localparam logic [1:0] EX_NONE  = 2'd0;
  localparam logic [1:0] EX_FUNC  = 2'd1;
  localparam logic [1:0] EX_ADDR  = 2'd2;
  localparam logic [1:0] EX_VALUE = 2'd3;

  localparam logic [2:0] REG_STATION   = 3'd0;
  localparam logic [2:0] REG_GAP       = 3'd1;
  localparam logic [2:0] REG_COIL_BASE = 3'd2;
  localparam logic [2:0] REG_COIL_CNT  = 3'd3;
  localparam logic [2:0] REG_HOLD_BASE = 3'd4;
  localparam logic [2:0] REG_HOLD_CNT  = 3'd5;
  localparam logic [2:0] REG_INP_BASE  = 3'd6;
  localparam logic [2:0] REG_INP_CNT   = 3'd7;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  rx_byte;
    logic [8:0]  local_index;
    logic [15:0] local_value;
  } in_item_t;

  typedef struct packed {
    logic [7:0] byte_0;
    logic [7:0] byte_1;
    logic [7:0] byte_2;
    logic [7:0] byte_3;
    logic [2:0] byte_count;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  station;
    logic [7:0]  gap;
    logic [15:0] coil_base;
    logic [9:0]  coil_count;
    logic [15:0] hold_base;
    logic [9:0]  hold_count;
    logic [15:0] inp_base;
    logic [9:0]  inp_count;
  } cfg_t;

  typedef enum logic [1:0] {K_BYTE, K_LOCAL, K_FRAME} qkind_t;

  typedef struct packed {
    qkind_t              kind;
    logic [QE_IDX_W-1:0] idx;
    logic [15:0]         data;
  } qent_t;

  typedef enum logic [1:0] {M_EXC, M_RCOIL, M_RREG, M_ECHO} rmode_t;

  typedef enum logic [4:0] {
    B_IDLE, B_SCAN, B_CHECK, B_EXEC,
    B_WC, B_WC_W, B_WH, B_WH_HI, B_WH_LO,
    B_HDR, B_RC, B_RC_W, B_RC_PUSH,
    B_RR, B_RR_HI, B_RR_LO, B_CRC0, B_CRC1
  } bstate_t;

endpackage

// ===== rtl/modbus_rtu_slave_engine.sv =====
// Modbus RTU slave engine: top level with the configuration registers.
// Each request (received byte, tick or local input register write) is taken by
// the front end and queued; in_stall rises only when the four-entry queue is
// full. The frame engine drains a byte or local write without leaving its idle
// state. A tick that closes a frame makes it scan the receive buffer, check the
// CRC and decide the action, then write the coils or holding registers, read the
// coils or registers, and send the reply bytes; reply groups of up to four bytes
// leave through an output register.
// The stores have no reset and need no clearing pass.
module modbus_rtu_slave_engine #(
  parameter int RX_DEPTH      = mrs_pkg::RX_DEPTH_DEF,
  parameter int COIL_DEPTH    = mrs_pkg::COIL_DEPTH_DEF,
  parameter int HOLDING_DEPTH = mrs_pkg::HOLDING_DEPTH_DEF,
  parameter int INPUT_DEPTH   = mrs_pkg::INPUT_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  mrs_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output mrs_pkg::out_item_t out_item,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  mrs_pkg::cfg_t  cfg;
  mrs_pkg::qent_t q_wdata, q_head;
  logic           q_push, q_pop, q_full, q_empty;
  logic [2:0]     ridx;

  assign pready = 1'b1;
  assign ridx   = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.station    <= 8'd1;
      cfg.gap        <= 8'd10;
      cfg.coil_base  <= '0;
      cfg.coil_count <= 10'd200;
      cfg.hold_base  <= '0;
      cfg.hold_count <= 10'd200;
      cfg.inp_base   <= '0;
      cfg.inp_count  <= 10'd200;
    end else if (psel && penable && pwrite && pready) begin
      case (ridx)
        mrs_pkg::REG_STATION:   cfg.station    <= pwdata[7:0];
        mrs_pkg::REG_GAP:       cfg.gap        <= pwdata[7:0];
        mrs_pkg::REG_COIL_BASE: cfg.coil_base  <= pwdata[15:0];
        mrs_pkg::REG_COIL_CNT:  cfg.coil_count <= pwdata[9:0];
        mrs_pkg::REG_HOLD_BASE: cfg.hold_base  <= pwdata[15:0];
        mrs_pkg::REG_HOLD_CNT:  cfg.hold_count <= pwdata[9:0];
        mrs_pkg::REG_INP_BASE:  cfg.inp_base   <= pwdata[15:0];
        mrs_pkg::REG_INP_CNT:   cfg.inp_count  <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ridx)
      mrs_pkg::REG_STATION:   prdata = {24'd0, cfg.station};
      mrs_pkg::REG_GAP:       prdata = {24'd0, cfg.gap};
      mrs_pkg::REG_COIL_BASE: prdata = {16'd0, cfg.coil_base};
      mrs_pkg::REG_COIL_CNT:  prdata = {22'd0, cfg.coil_count};
      mrs_pkg::REG_HOLD_BASE: prdata = {16'd0, cfg.hold_base};
      mrs_pkg::REG_HOLD_CNT:  prdata = {22'd0, cfg.hold_count};
      mrs_pkg::REG_INP_BASE:  prdata = {16'd0, cfg.inp_base};
      mrs_pkg::REG_INP_CNT:   prdata = {22'd0, cfg.inp_count};
      default:                prdata = '0;
    endcase
  end

  mrs_front #(.RX_DEPTH(RX_DEPTH)) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .station  (cfg.station),
    .gap      (cfg.gap),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_entry  (q_wdata)
  );

  mrs_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .head  (q_head),
    .full  (q_full),
    .empty (q_empty)
  );

  mrs_back #(
    .RX_DEPTH      (RX_DEPTH),
    .COIL_DEPTH    (COIL_DEPTH),
    .HOLDING_DEPTH (HOLDING_DEPTH),
    .INPUT_DEPTH   (INPUT_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_empty   (q_empty),
    .head      (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

// ===== rtl/mrs_front.sv =====
// Front end: frame delimiting, address filter and classification of requests.
module mrs_front #(
  parameter int RX_DEPTH = mrs_pkg::RX_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  mrs_pkg::in_item_t in_item,
  input  logic [7:0]        station,
  input  logic [7:0]        gap,
  input  logic              q_full,
  output logic              q_push,
  output mrs_pkg::qent_t    q_entry
);

  localparam int PW = $clog2(RX_DEPTH + 1);

  logic [PW-1:0] pos, pos_next;
  logic          accepting, accepting_next;
  logic [8:0]    idle, idle_next;
  logic [7:0]    first_byte, first_byte_next;
  logic [8:0]    idle_inc;
  logic          accept;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign idle_inc = idle + 9'd1;

  always_comb begin
    pos_next        = pos;
    accepting_next  = accepting;
    idle_next       = idle;
    first_byte_next = first_byte;
    q_push          = 1'b0;
    q_entry.kind    = mrs_pkg::K_BYTE;
    q_entry.idx     = mrs_pkg::QE_IDX_W'(pos);
    q_entry.data    = {8'h00, in_item.rx_byte};
    if (accept) begin
      case (in_item.cmd)
        mrs_pkg::CMD_BYTE: begin
          if (accepting) begin
            if (pos == '0) begin
              first_byte_next = in_item.rx_byte;
              if (in_item.rx_byte != station) accepting_next = 1'b0;
            end
            if (pos < PW'(RX_DEPTH)) begin
              q_push   = 1'b1;
              pos_next = pos + PW'(1);
            end
          end
          idle_next = '0;
        end
        mrs_pkg::CMD_TICK: begin
          if (idle_inc > {1'b0, gap}) begin
            pos_next       = '0;
            accepting_next = 1'b1;
            idle_next      = '0;
            q_entry.kind   = mrs_pkg::K_FRAME;
            q_push         = (pos >= PW'(8)) && (first_byte == station);
          end else begin
            idle_next = idle_inc;
          end
        end
        mrs_pkg::CMD_LOCAL: begin
          q_push       = 1'b1;
          q_entry.kind = mrs_pkg::K_LOCAL;
          q_entry.idx  = mrs_pkg::QE_IDX_W'(in_item.local_index);
          q_entry.data = in_item.local_value;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos        <= '0;
      accepting  <= 1'b0;
      idle       <= '0;
      first_byte <= '0;
    end else begin
      pos        <= pos_next;
      accepting  <= accepting_next;
      idle       <= idle_next;
      first_byte <= first_byte_next;
    end
  end

endmodule

// ===== rtl/mrs_queue.sv =====
// Short request queue between the front end and the frame engine.
module mrs_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  mrs_pkg::qent_t wdata,
  input  logic           pop,
  output mrs_pkg::qent_t head,
  output logic           full,
  output logic           empty
);

  localparam int AW = $clog2(mrs_pkg::Q_DEPTH);

  mrs_pkg::qent_t  ent [mrs_pkg::Q_DEPTH];
  logic [AW-1:0]   wptr, rptr;
  logic [AW:0]     cnt;

  assign full  = (cnt == (AW+1)'(mrs_pkg::Q_DEPTH));
  assign empty = (cnt == '0);
  assign head  = ent[rptr];

  always_ff @(posedge clk) begin
    if (push) ent[wptr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      cnt  <= '0;
    end else begin
      if (push) wptr <= wptr + AW'(1);
      if (pop)  rptr <= rptr + AW'(1);
      cnt <= cnt + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

endmodule

// ===== rtl/mrs_back.sv =====
// Frame engine: receive buffer, data stores, request execution and reply packing.
module mrs_back #(
  parameter int RX_DEPTH      = mrs_pkg::RX_DEPTH_DEF,
  parameter int COIL_DEPTH    = mrs_pkg::COIL_DEPTH_DEF,
  parameter int HOLDING_DEPTH = mrs_pkg::HOLDING_DEPTH_DEF,
  parameter int INPUT_DEPTH   = mrs_pkg::INPUT_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  mrs_pkg::cfg_t      cfg,
  input  logic               q_empty,
  input  mrs_pkg::qent_t     head,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output mrs_pkg::out_item_t out_item
);

  localparam int RA = $clog2(RX_DEPTH);
  localparam int LW = $clog2(RX_DEPTH + 1);
  localparam int CA = $clog2(COIL_DEPTH);
  localparam int HA = $clog2(HOLDING_DEPTH);
  localparam int IA = $clog2(INPUT_DEPTH);

  function automatic logic [15:0] crc_upd(input logic [15:0] c, input logic [7:0] d);
    logic [15:0] x;
    x = c ^ {8'h00, d};
    for (int k = 0; k < 8; k++) x = x[0] ? ((x >> 1) ^ 16'hA001) : (x >> 1);
    return x;
  endfunction

  function automatic logic in_win(input logic [15:0] base, input logic [9:0] count,
                                  input logic [12:0] depth, input logic [15:0] adr,
                                  input logic [15:0] qq);
    logic [12:0] eff;
    logic [16:0] sum;
    eff = ({3'b000, count} < depth) ? {3'b000, count} : depth;
    sum = {1'b0, adr - base} + {1'b0, qq};
    return (adr >= base) && (sum <= {4'b0000, eff});
  endfunction

  // memories
  logic [7:0]  rx_mem   [RX_DEPTH];
  logic        coil_mem [COIL_DEPTH];
  logic [15:0] hold_mem [HOLDING_DEPTH];
  logic [15:0] inp_mem  [INPUT_DEPTH];

  logic          rx_we;
  logic [RA-1:0] rx_waddr, rx_raddr;
  logic [7:0]    rx_q;
  logic          coil_we, coil_wdata, coil_q;
  logic [CA-1:0] coil_waddr, coil_raddr;
  logic          hold_we;
  logic [HA-1:0] hold_waddr, hold_raddr;
  logic [15:0]   hold_wdata, hold_q;
  logic          inp_we;
  logic [IA-1:0] inp_raddr;
  logic [15:0]   inp_q;

  mrs_pkg::bstate_t state, state_next;
  mrs_pkg::rmode_t  mode;

  logic [LW-1:0] len, scan_i, pidx;
  logic          pend, issue;
  logic [15:0]   crc, txcrc;
  logic [7:0]    b [7];
  logic [7:0]    clo, chi;
  logic [7:0]    rh [6];
  logic [2:0]    hcnt, nhdr;
  logic [1:0]    err;
  logic [15:0]   q, off;
  logic [10:0]   cnt;
  logic [7:0]    acc, tmp;

  logic          push, push_last, push_nocrc, out_free;
  logic [7:0]    push_byte;

  // request checks, evaluated from the captured header
  logic [7:0]    fc;
  logic [15:0]   adr, qv, sel_base, qq;
  logic [9:0]    sel_cnt;
  logic [12:0]   sel_depth;
  logic [16:0]   bc_c, bc_h;
  logic          win_ok, len_bad, crc_bad;
  logic [1:0]    chk_err;
  mrs_pkg::rmode_t chk_mode;

  assign fc  = b[1];
  assign adr = {b[2], b[3]};
  assign qv  = {b[4], b[5]};
  assign bc_c = ({1'b0, qv} + 17'd7) >> 3;
  assign bc_h = {qv, 1'b0};
  assign len_bad = (len > LW'(250)) || (len < LW'(8));
  assign crc_bad = (crc != {chi, clo});

  always_comb begin
    sel_base  = cfg.coil_base;
    sel_cnt   = cfg.coil_count;
    sel_depth = 13'(COIL_DEPTH);
    if (fc == mrs_pkg::FC_READ_HOLDING || fc == mrs_pkg::FC_WRITE_REG ||
        fc == mrs_pkg::FC_WRITE_REGS) begin
      sel_base  = cfg.hold_base;
      sel_cnt   = cfg.hold_count;
      sel_depth = 13'(HOLDING_DEPTH);
    end else if (fc == mrs_pkg::FC_READ_INPUT) begin
      sel_base  = cfg.inp_base;
      sel_cnt   = cfg.inp_count;
      sel_depth = 13'(INPUT_DEPTH);
    end
    qq = (fc == mrs_pkg::FC_WRITE_COIL || fc == mrs_pkg::FC_WRITE_REG) ? 16'd1 : qv;
    win_ok = in_win(sel_base, sel_cnt, sel_depth, adr, qq);

    chk_err  = mrs_pkg::EX_NONE;
    chk_mode = mrs_pkg::M_ECHO;
    case (fc)
      mrs_pkg::FC_READ_COILS, mrs_pkg::FC_READ_DISCRETE: begin
        chk_mode = mrs_pkg::M_RCOIL;
        if (qv == 16'd0 || qv > 16'd960) chk_err = mrs_pkg::EX_VALUE;
        else if (!win_ok) chk_err = mrs_pkg::EX_ADDR;
      end
      mrs_pkg::FC_READ_HOLDING, mrs_pkg::FC_READ_INPUT: begin
        chk_mode = mrs_pkg::M_RREG;
        if (qv == 16'd0 || qv > 16'd125) chk_err = mrs_pkg::EX_VALUE;
        else if (!win_ok) chk_err = mrs_pkg::EX_ADDR;
      end
      mrs_pkg::FC_WRITE_COIL: begin
        if (!win_ok) chk_err = mrs_pkg::EX_ADDR;
        else if (qv != 16'hFF00 && qv != 16'h0000) chk_err = mrs_pkg::EX_VALUE;
      end
      mrs_pkg::FC_WRITE_REG: begin
        if (!win_ok) chk_err = mrs_pkg::EX_ADDR;
      end
      mrs_pkg::FC_WRITE_COILS: begin
        if (qv == 16'd0 || qv > 16'd1968 || {9'd0, b[6]} != bc_c ||
            18'd9 + {1'b0, bc_c} > 18'(len)) chk_err = mrs_pkg::EX_VALUE;
        else if (!win_ok) chk_err = mrs_pkg::EX_ADDR;
      end
      mrs_pkg::FC_WRITE_REGS: begin
        if (qv == 16'd0 || qv > 16'd123 || {9'd0, b[6]} != bc_h ||
            18'd9 + {1'b0, bc_h} > 18'(len)) chk_err = mrs_pkg::EX_VALUE;
        else if (!win_ok) chk_err = mrs_pkg::EX_ADDR;
      end
      default: chk_err = mrs_pkg::EX_FUNC;
    endcase
    // function code outranks length and CRC, which outrank the rest
    if (chk_err != mrs_pkg::EX_FUNC && (len_bad || crc_bad)) chk_err = mrs_pkg::EX_VALUE;
    if (chk_err != mrs_pkg::EX_NONE) chk_mode = mrs_pkg::M_EXC;
  end

  assign out_free = !out_valid || !out_stall;
  assign issue    = (scan_i < len);

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    rx_we      = 1'b0;
    rx_waddr   = RA'(head.idx);
    rx_raddr   = '0;
    coil_we    = 1'b0;
    coil_waddr = CA'(off + 16'(cnt));
    coil_wdata = rx_q[cnt[2:0]];
    coil_raddr = CA'(off + 16'(cnt));
    hold_we    = 1'b0;
    hold_waddr = HA'(off + 16'(cnt));
    hold_wdata = {tmp, rx_q};
    hold_raddr = HA'(off + 16'(cnt));
    inp_we     = 1'b0;
    inp_raddr  = IA'(off + 16'(cnt));
    push       = 1'b0;
    push_byte  = rh[hcnt];
    push_last  = 1'b0;
    push_nocrc = 1'b0;
    case (state)
      mrs_pkg::B_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          case (head.kind)
            mrs_pkg::K_BYTE:  rx_we = 1'b1;
            mrs_pkg::K_LOCAL: inp_we = (32'(head.idx) < INPUT_DEPTH);
            mrs_pkg::K_FRAME: state_next = mrs_pkg::B_SCAN;
            default: ;
          endcase
        end
      end
      mrs_pkg::B_SCAN: begin
        rx_raddr = RA'(scan_i);
        if (!issue && !pend) state_next = mrs_pkg::B_CHECK;
      end
      mrs_pkg::B_CHECK: state_next = mrs_pkg::B_EXEC;
      mrs_pkg::B_EXEC: begin
        state_next = mrs_pkg::B_HDR;
        if (err == mrs_pkg::EX_NONE) begin
          case (fc)
            mrs_pkg::FC_WRITE_COIL: begin
              coil_we    = 1'b1;
              coil_waddr = CA'(off);
              coil_wdata = (q == 16'hFF00);
            end
            mrs_pkg::FC_WRITE_REG: begin
              hold_we    = 1'b1;
              hold_waddr = HA'(off);
              hold_wdata = q;
            end
            mrs_pkg::FC_WRITE_COILS: state_next = mrs_pkg::B_WC;
            mrs_pkg::FC_WRITE_REGS:  state_next = mrs_pkg::B_WH;
            default: ;
          endcase
        end
      end
      mrs_pkg::B_WC: begin
        rx_raddr   = RA'(11'd7 + (cnt >> 3));
        state_next = mrs_pkg::B_WC_W;
      end
      mrs_pkg::B_WC_W: begin
        coil_we    = 1'b1;
        state_next = ({5'd0, cnt} + 16'd1 == q) ? mrs_pkg::B_HDR : mrs_pkg::B_WC;
      end
      mrs_pkg::B_WH: begin
        rx_raddr   = RA'(12'd7 + {cnt, 1'b0});
        state_next = mrs_pkg::B_WH_HI;
      end
      mrs_pkg::B_WH_HI: begin
        rx_raddr   = RA'(12'd8 + {cnt, 1'b0});
        state_next = mrs_pkg::B_WH_LO;
      end
      mrs_pkg::B_WH_LO: begin
        hold_we    = 1'b1;
        state_next = ({5'd0, cnt} + 16'd1 == q) ? mrs_pkg::B_HDR : mrs_pkg::B_WH;
      end
      mrs_pkg::B_HDR: begin
        push = 1'b1;
        if (out_free && hcnt == nhdr - 3'd1) begin
          case (mode)
            mrs_pkg::M_RCOIL: state_next = mrs_pkg::B_RC;
            mrs_pkg::M_RREG:  state_next = mrs_pkg::B_RR;
            default:          state_next = mrs_pkg::B_CRC0;
          endcase
        end
      end
      mrs_pkg::B_RC: state_next = mrs_pkg::B_RC_W;
      mrs_pkg::B_RC_W: begin
        if (cnt[2:0] == 3'd7 || {5'd0, cnt} + 16'd1 == q) state_next = mrs_pkg::B_RC_PUSH;
        else state_next = mrs_pkg::B_RC;
      end
      mrs_pkg::B_RC_PUSH: begin
        push      = 1'b1;
        push_byte = acc;
        if (out_free) state_next = ({5'd0, cnt} == q) ? mrs_pkg::B_CRC0 : mrs_pkg::B_RC;
      end
      mrs_pkg::B_RR: state_next = mrs_pkg::B_RR_HI;
      mrs_pkg::B_RR_HI: begin
        push      = 1'b1;
        push_byte = (fc == mrs_pkg::FC_READ_HOLDING) ? hold_q[15:8] : inp_q[15:8];
        if (out_free) state_next = mrs_pkg::B_RR_LO;
      end
      mrs_pkg::B_RR_LO: begin
        push      = 1'b1;
        push_byte = (fc == mrs_pkg::FC_READ_HOLDING) ? hold_q[7:0] : inp_q[7:0];
        if (out_free) begin
          state_next = ({5'd0, cnt} + 16'd1 == q) ? mrs_pkg::B_CRC0 : mrs_pkg::B_RR;
        end
      end
      mrs_pkg::B_CRC0: begin
        push       = 1'b1;
        push_nocrc = 1'b1;
        push_byte  = txcrc[7:0];
        if (out_free) state_next = mrs_pkg::B_CRC1;
      end
      mrs_pkg::B_CRC1: begin
        push       = 1'b1;
        push_nocrc = 1'b1;
        push_last  = 1'b1;
        push_byte  = txcrc[15:8];
        if (out_free) state_next = mrs_pkg::B_IDLE;
      end
      default: state_next = mrs_pkg::B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= mrs_pkg::B_IDLE;
    else     state <= state_next;
  end

  // memory ports
  always_ff @(posedge clk) begin
    if (rx_we) rx_mem[rx_waddr] <= head.data[7:0];
    rx_q <= rx_mem[rx_raddr];
  end

  always_ff @(posedge clk) begin
    if (coil_we) coil_mem[coil_waddr] <= coil_wdata;
    coil_q <= coil_mem[coil_raddr];
  end

  always_ff @(posedge clk) begin
    if (hold_we) hold_mem[hold_waddr] <= hold_wdata;
    hold_q <= hold_mem[hold_raddr];
  end

  always_ff @(posedge clk) begin
    if (inp_we) inp_mem[IA'(head.idx)] <= head.data;
    inp_q <= inp_mem[inp_raddr];
  end

  // sequencer datapath
  always_ff @(posedge clk) begin
    case (state)
      mrs_pkg::B_IDLE: begin
        len    <= LW'(head.idx);
        scan_i <= '0;
        pend   <= 1'b0;
        crc    <= 16'hFFFF;
      end
      mrs_pkg::B_SCAN: begin
        pend <= issue;
        pidx <= scan_i;
        if (issue) scan_i <= scan_i + LW'(1);
        if (pend) begin
          if (pidx < LW'(7)) b[pidx[2:0]] <= rx_q;
          if (pidx == len - LW'(2)) clo <= rx_q;
          if (pidx == len - LW'(1)) chi <= rx_q;
          if (pidx < len - LW'(2)) crc <= crc_upd(crc, rx_q);
        end
      end
      mrs_pkg::B_CHECK: begin
        err   <= chk_err;
        mode  <= chk_mode;
        q     <= qv;
        off   <= adr - sel_base;
        cnt   <= '0;
        acc   <= '0;
        hcnt  <= '0;
        rh[0] <= b[0];
        rh[1] <= (chk_err != mrs_pkg::EX_NONE) ? (fc | 8'h80) : fc;
        case (chk_mode)
          mrs_pkg::M_EXC:   rh[2] <= {6'd0, chk_err};
          mrs_pkg::M_RCOIL: rh[2] <= bc_c[7:0];
          mrs_pkg::M_RREG:  rh[2] <= bc_h[7:0];
          default:          rh[2] <= b[2];
        endcase
        rh[3] <= b[3];
        rh[4] <= b[4];
        rh[5] <= b[5];
        nhdr  <= (chk_mode == mrs_pkg::M_ECHO) ? 3'd6 : 3'd3;
      end
      mrs_pkg::B_WC_W:  cnt <= cnt + 11'd1;
      mrs_pkg::B_WH_HI: tmp <= rx_q;
      mrs_pkg::B_WH_LO: cnt <= cnt + 11'd1;
      mrs_pkg::B_HDR:   if (out_free) hcnt <= hcnt + 3'd1;
      mrs_pkg::B_RC_W: begin
        acc <= acc | ({7'd0, coil_q} << cnt[2:0]);
        cnt <= cnt + 11'd1;
      end
      mrs_pkg::B_RC_PUSH: if (out_free) acc <= '0;
      mrs_pkg::B_RR_LO:   if (out_free) cnt <= cnt + 11'd1;
      default: ;
    endcase
    if (state == mrs_pkg::B_CHECK) txcrc <= 16'hFFFF;
    else if (push && out_free && !push_nocrc) txcrc <= crc_upd(txcrc, push_byte);
  end

  // reply packer: up to four bytes per group, output register toward the sink
  logic [7:0] gbuf [3];
  logic [1:0] gcnt;

  always_ff @(posedge clk) begin
    if (push && out_free && (gcnt == 2'd3 || push_last)) begin
      out_item.byte_0     <= (gcnt == 2'd0) ? push_byte : gbuf[0];
      out_item.byte_1     <= (gcnt == 2'd1) ? push_byte : (gcnt > 2'd1) ? gbuf[1] : 8'h00;
      out_item.byte_2     <= (gcnt == 2'd2) ? push_byte : (gcnt > 2'd2) ? gbuf[2] : 8'h00;
      out_item.byte_3     <= (gcnt == 2'd3) ? push_byte : 8'h00;
      out_item.byte_count <= {1'b0, gcnt} + 3'd1;
      out_item.last       <= push_last;
    end else if (push && out_free) begin
      gbuf[gcnt] <= push_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      gcnt      <= '0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (push && out_free) begin
        if (gcnt == 2'd3 || push_last) begin
          out_valid <= 1'b1;
          gcnt      <= '0;
        end else begin
          gcnt <= gcnt + 2'd1;
        end
      end
    end
  end

endmodule

// ===== rtl/mrs_checker.sv =====
// Port-level checks of the reply channel, bound to the top level.
module mrs_checker (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_stall,
  input mrs_pkg::out_item_t out_item
);

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_item.byte_count == 3'd1 || out_item.byte_count == 3'd2 ||
                   out_item.byte_count == 3'd3 || out_item.byte_count == 3'd4))
    else $error("reply group byte count out of range");

  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_item.byte_count == 3'd1) |->
      (out_item.byte_1 == 8'h00 && out_item.byte_2 == 8'h00 && out_item.byte_3 == 8'h00))
    else $error("unused reply bytes not zero");

  a_short_is_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_item.byte_count != 3'd4) |-> out_item.last)
    else $error("short group before end of reply");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(out_item)))
    else $error("stalled reply group changed");

  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("reply valid after reset");

endmodule

bind modbus_rtu_slave_engine mrs_checker u_mrs_checker (.*);

// ===== sim/tb_modbus_rtu_slave_engine.sv =====
// Self-checking testbench of the Modbus RTU slave engine: request stimulus, reply prediction.
module tb_modbus_rtu_slave_engine;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCH_LIMIT  = 20000;
  localparam int DRAIN_CYCLES = 1200;
  localparam int LONG_HOLD    = 400;
  localparam int STORE_DEPTH  = 512;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  mrs_pkg::in_item_t   in_item = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  mrs_pkg::out_item_t  out_item;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [4:0]          paddr = '0;
  logic [31:0]         pwdata = '0;
  logic [31:0]         prdata;
  logic                pready;

  modbus_rtu_slave_engine dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // slave shadow state
  logic [7:0]  rx_buf [0:255];
  int          rx_pos = 0;
  bit          rx_open = 1'b0;
  int          idle_cnt = 0;
  bit          coil_mem [0:STORE_DEPTH-1];
  logic [15:0] hold_mem [0:STORE_DEPTH-1];
  logic [15:0] inp_mem  [0:STORE_DEPTH-1];
  int c_st = 1, c_gap = 10, c_cb = 0, c_cc = 200, c_hb = 0, c_hc = 200, c_ib = 0, c_ic = 200;

  mrs_pkg::in_item_t  pending_req [$];
  mrs_pkg::out_item_t reply_groups [$];

  int  errors = 0, n_req = 0, n_groups = 0, n_replies = 0, n_exc = 0, quiet = 0;
  bit  in_taken = 1'b0, out_taken = 1'b0;
  bit  tx_burst = 1'b0, rx_burst = 1'b0, hold_req = 1'b0, in_next, stall_next;
  int  tx_gap = 0, rx_wait = 0, hold_left = 0;

  function automatic logic [15:0] crc_add(logic [15:0] c, logic [7:0] d);
    c ^= {8'h00, d};
    for (int k = 0; k < 8; k++) c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
    return c;
  endfunction

  function automatic int eff_of(int count);
    return count < STORE_DEPTH ? count : STORE_DEPTH;
  endfunction

  function automatic bit win_ok(int base, int count, int adr, int q);
    if (adr < base) return 1'b0;
    return (adr - base) + q <= eff_of(count);
  endfunction

  task automatic slave_predict(mrs_pkg::in_item_t it);
    logic [7:0]  r [0:263];
    logic [15:0] c, v;
    int len, fc, err, n, adr, q, off, bc, rl, g, cnt, base, count;
    bit hold;
    mrs_pkg::out_item_t o;
    case (it.cmd)
      mrs_pkg::CMD_BYTE: begin
        if (rx_open) begin
          if (rx_pos == 0 && it.rx_byte != c_st[7:0]) rx_open = 1'b0;
          if (rx_pos < 256) begin
            rx_buf[rx_pos] = it.rx_byte;
            rx_pos++;
          end
        end
        idle_cnt = 0;
      end
      mrs_pkg::CMD_LOCAL: inp_mem[it.local_index] = it.local_value;
      mrs_pkg::CMD_TICK: begin
        if (idle_cnt < 16'hFFFF) idle_cnt++;
        if (idle_cnt > c_gap) begin
          len = rx_pos;
          rx_pos = 0;
          rx_open = 1'b1;
          idle_cnt = 0;
          if (len >= 8 && rx_buf[0] == c_st[7:0]) begin
            fc = rx_buf[1];
            err = 0;
            n = 6;
            r[0] = rx_buf[0];
            r[1] = rx_buf[1];
            if (fc == 0 || (fc > 6 && fc < 15) || fc > 16) err = mrs_pkg::EX_FUNC;
            else if (len > 250) err = mrs_pkg::EX_VALUE;
            else begin
              c = 16'hFFFF;
              for (int i = 0; i < len - 2; i++) c = crc_add(c, rx_buf[i]);
              if (c != {rx_buf[len-1], rx_buf[len-2]}) err = mrs_pkg::EX_VALUE;
            end
            if (err == 0) begin
              adr = {rx_buf[2], rx_buf[3]};
              q = {rx_buf[4], rx_buf[5]};
              for (int i = 2; i < 6; i++) r[i] = rx_buf[i];
              case (fc)
                mrs_pkg::FC_READ_COILS, mrs_pkg::FC_READ_DISCRETE: begin
                  if (q == 0 || q > 960) err = mrs_pkg::EX_VALUE;
                  else if (!win_ok(c_cb, c_cc, adr, q)) err = mrs_pkg::EX_ADDR;
                  else begin
                    off = adr - c_cb;
                    bc = (q + 7) / 8;
                    r[2] = bc[7:0];
                    for (int i = 0; i < bc; i++) r[3+i] = 8'h00;
                    for (int i = 0; i < q; i++) if (coil_mem[off+i]) r[3+i/8][i%8] = 1'b1;
                    n = 3 + bc;
                  end
                end
                mrs_pkg::FC_READ_HOLDING, mrs_pkg::FC_READ_INPUT: begin
                  hold = (fc == mrs_pkg::FC_READ_HOLDING);
                  base = hold ? c_hb : c_ib;
                  count = hold ? c_hc : c_ic;
                  if (q == 0 || q > 125) err = mrs_pkg::EX_VALUE;
                  else if (!win_ok(base, count, adr, q)) err = mrs_pkg::EX_ADDR;
                  else begin
                    off = adr - base;
                    r[2] = 8'(2 * q);
                    for (int i = 0; i < q; i++) begin
                      v = hold ? hold_mem[off+i] : inp_mem[off+i];
                      r[3+2*i] = v[15:8];
                      r[4+2*i] = v[7:0];
                    end
                    n = 3 + 2 * q;
                  end
                end
                mrs_pkg::FC_WRITE_COIL: begin
                  if (!win_ok(c_cb, c_cc, adr, 1)) err = mrs_pkg::EX_ADDR;
                  else if (q == 16'hFF00) coil_mem[adr-c_cb] = 1'b1;
                  else if (q == 0) coil_mem[adr-c_cb] = 1'b0;
                  else err = mrs_pkg::EX_VALUE;
                end
                mrs_pkg::FC_WRITE_REG: begin
                  if (!win_ok(c_hb, c_hc, adr, 1)) err = mrs_pkg::EX_ADDR;
                  else hold_mem[adr-c_hb] = q[15:0];
                end
                mrs_pkg::FC_WRITE_COILS: begin
                  bc = (q + 7) / 8;
                  if (q == 0 || q > 1968 || rx_buf[6] != bc || 9 + bc > len)
                    err = mrs_pkg::EX_VALUE;
                  else if (!win_ok(c_cb, c_cc, adr, q)) err = mrs_pkg::EX_ADDR;
                  else begin
                    off = adr - c_cb;
                    for (int i = 0; i < q; i++) coil_mem[off+i] = rx_buf[7+i/8][i%8];
                  end
                end
                default: begin
                  bc = 2 * q;
                  if (q == 0 || q > 123 || rx_buf[6] != bc || 9 + bc > len)
                    err = mrs_pkg::EX_VALUE;
                  else if (!win_ok(c_hb, c_hc, adr, q)) err = mrs_pkg::EX_ADDR;
                  else begin
                    off = adr - c_hb;
                    for (int i = 0; i < q; i++)
                      hold_mem[off+i] = {rx_buf[7+2*i], rx_buf[8+2*i]};
                  end
                end
              endcase
            end
            if (err != 0) begin
              r[1] = 8'(fc) | 8'h80;
              r[2] = 8'(err);
              n = 3;
              n_exc++;
            end
            c = 16'hFFFF;
            for (int i = 0; i < n; i++) c = crc_add(c, r[i]);
            r[n] = c[7:0];
            r[n+1] = c[15:8];
            rl = n + 2;
            g = (rl + 3) / 4;
            n_replies++;
            for (int k = 0; k < g; k++) begin
              cnt = (rl - 4 * k > 4) ? 4 : rl - 4 * k;
              o.byte_0 = r[4*k];
              o.byte_1 = cnt > 1 ? r[4*k+1] : 8'h00;
              o.byte_2 = cnt > 2 ? r[4*k+2] : 8'h00;
              o.byte_3 = cnt > 3 ? r[4*k+3] : 8'h00;
              o.byte_count = 3'(cnt);
              o.last = (k + 1 == g);
              reply_groups.push_back(o);
            end
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic report_mismatch(string what, int got, int want);
    errors++;
    $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
  endtask

  // sample both handshakes at the rising edge
  always @(posedge clk) begin
    mrs_pkg::out_item_t e;
    in_taken = 1'b0;
    out_taken = 1'b0;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        in_taken = 1'b1;
        n_req++;
        slave_predict(in_item);
      end
      if (out_valid && !out_stall) begin
        out_taken = 1'b1;
        n_groups++;
        if (reply_groups.size() == 0)
          report_mismatch("unexpected reply group", int'(out_item.byte_0), 0);
        else begin
          e = reply_groups.pop_front();
          if (out_item.byte_0 !== e.byte_0) report_mismatch("byte_0", out_item.byte_0, e.byte_0);
          if (out_item.byte_1 !== e.byte_1) report_mismatch("byte_1", out_item.byte_1, e.byte_1);
          if (out_item.byte_2 !== e.byte_2) report_mismatch("byte_2", out_item.byte_2, e.byte_2);
          if (out_item.byte_3 !== e.byte_3) report_mismatch("byte_3", out_item.byte_3, e.byte_3);
          if (out_item.byte_count !== e.byte_count)
            report_mismatch("byte_count", out_item.byte_count, e.byte_count);
          if (out_item.last !== e.last) report_mismatch("last", out_item.last, e.last);
        end
      end
      quiet = (in_taken || out_taken) ? 0 : quiet + 1;
      if (quiet >= WATCH_LIMIT) begin
        $display("watchdog: %0d cycles without progress", quiet);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // request driver
  always @(negedge clk) begin
    if (!rst) begin
      in_next = 1'b0;
      if (in_valid && !in_taken) in_next = 1'b1;
      else begin
        if (in_taken) begin
          if ($urandom_range(0, 40) == 0) tx_burst = !tx_burst;
          tx_gap = tx_burst ? 0 : $urandom_range(0, 6);
        end
        if (tx_gap > 0) tx_gap--;
        else if (pending_req.size() > 0) begin
          in_item <= pending_req.pop_front();
          in_next = 1'b1;
        end
      end
      in_valid <= in_next;
    end
  end

  // reply receiver
  always @(negedge clk) begin
    if (!rst) begin
      stall_next = 1'b0;
      if (hold_req) begin
        hold_left = LONG_HOLD;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        stall_next = 1'b1;
      end else begin
        if (out_taken) begin
          if ($urandom_range(0, 30) == 0) rx_burst = !rx_burst;
          rx_wait = rx_burst ? 0 : $urandom_range(0, 6);
        end
        if (rx_wait > 0) begin
          rx_wait--;
          stall_next = 1'b1;
        end
      end
      out_stall <= stall_next;
    end
  end

  task automatic cfg_write(logic [2:0] idx, int val);
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      mrs_pkg::REG_STATION:   c_st  = val & 8'hFF;
      mrs_pkg::REG_GAP:       c_gap = val & 8'hFF;
      mrs_pkg::REG_COIL_BASE: c_cb  = val & 16'hFFFF;
      mrs_pkg::REG_COIL_CNT:  c_cc  = val & 10'h3FF;
      mrs_pkg::REG_HOLD_BASE: c_hb  = val & 16'hFFFF;
      mrs_pkg::REG_HOLD_CNT:  c_hc  = val & 10'h3FF;
      mrs_pkg::REG_INP_BASE:  c_ib  = val & 16'hFFFF;
      default:                c_ic  = val & 10'h3FF;
    endcase
  endtask

  task automatic set_windows(int st, int gap, int cb, int cc, int hb, int hc, int ib, int ic);
    cfg_write(mrs_pkg::REG_STATION, st);
    cfg_write(mrs_pkg::REG_GAP, gap);
    cfg_write(mrs_pkg::REG_COIL_BASE, cb);
    cfg_write(mrs_pkg::REG_COIL_CNT, cc);
    cfg_write(mrs_pkg::REG_HOLD_BASE, hb);
    cfg_write(mrs_pkg::REG_HOLD_CNT, hc);
    cfg_write(mrs_pkg::REG_INP_BASE, ib);
    cfg_write(mrs_pkg::REG_INP_CNT, ic);
  endtask

  // block idle: all requests taken, all replies back, frame scan finished
  task automatic settle();
    while (pending_req.size() > 0 || in_valid) @(posedge clk);
    while (reply_groups.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic push_req(logic [1:0] cmd, logic [7:0] b);
    mrs_pkg::in_item_t it;
    it.cmd = cmd;
    it.rx_byte = b;
    it.local_index = $urandom;
    it.local_value = $urandom;
    pending_req.push_back(it);
  endtask

  task automatic push_local(logic [8:0] idx, logic [15:0] val);
    mrs_pkg::in_item_t it;
    it.cmd = mrs_pkg::CMD_LOCAL;
    it.rx_byte = $urandom;
    it.local_index = idx;
    it.local_value = val;
    pending_req.push_back(it);
  endtask

  task automatic close_frame();
    for (int i = 0; i <= c_gap; i++) push_req(mrs_pkg::CMD_TICK, $urandom);
  endtask

  // appends the CRC (spoilt on request), sends the bytes and closes the frame
  task automatic push_frame(logic [7:0] f [$], bit good);
    logic [15:0] c;
    c = 16'hFFFF;
    foreach (f[i]) c = crc_add(c, f[i]);
    f.push_back(good ? c[7:0] : ~c[7:0]);
    f.push_back(c[15:8]);
    foreach (f[i]) begin
      push_req(mrs_pkg::CMD_BYTE, f[i]);
      // idle ticks inside the frame that stay under the gap
      if (c_gap > 0 && $urandom_range(0, 11) == 0)
        repeat ($urandom_range(0, c_gap < 4 ? c_gap : 4)) push_req(mrs_pkg::CMD_TICK, $urandom);
    end
    close_frame();
  endtask

  // request header with optional byte count field and data; nd < 0 means none
  task automatic send_pdu(int st, int fc, int adr, int w, int nd = -1, int bcf = 0,
                          bit good = 1'b1);
    logic [7:0] f [$];
    f = {8'(st), 8'(fc), 8'(adr >> 8), 8'(adr), 8'(w >> 8), 8'(w)};
    if (nd >= 0) begin
      f.push_back(8'(bcf));
      repeat (nd) f.push_back($urandom);
    end
    push_frame(f, good);
  endtask

  function automatic int pick_q(int lim, int count);
    int m;
    m = eff_of(count) < lim ? eff_of(count) : lim;
    if ($urandom_range(0, 19) == 0) return $urandom_range(0, 16'hFFFF);
    if (m < 1) return $urandom_range(1, lim);
    if ($urandom_range(0, 3) != 0 && m > 8) m = 8;
    return $urandom_range(1, m);
  endfunction

  function automatic int pick_adr(int base, int count, int q);
    if ($urandom_range(0, 9) == 0 || q > eff_of(count)) return $urandom_range(0, 16'hFFFF);
    return (base + $urandom_range(0, eff_of(count) - q)) & 16'hFFFF;
  endfunction

  task automatic rand_request();
    int fc, st, q, adr, bc;
    fc = $urandom_range(0, 99) < 6 ? $urandom_range(0, 255) : 0;
    if (fc == 0)
      case ($urandom_range(0, 7))
        0: fc = mrs_pkg::FC_READ_COILS;   1: fc = mrs_pkg::FC_READ_DISCRETE;
        2: fc = mrs_pkg::FC_READ_HOLDING; 3: fc = mrs_pkg::FC_READ_INPUT;
        4: fc = mrs_pkg::FC_WRITE_COIL;   5: fc = mrs_pkg::FC_WRITE_REG;
        6: fc = mrs_pkg::FC_WRITE_COILS;  default: fc = mrs_pkg::FC_WRITE_REGS;
      endcase
    st = $urandom_range(0, 19) == 0 ? $urandom_range(0, 255) : c_st;
    case (fc)
      mrs_pkg::FC_READ_COILS, mrs_pkg::FC_READ_DISCRETE: begin
        q = pick_q(960, c_cc);
        send_pdu(st, fc, pick_adr(c_cb, c_cc, q), q, -1, 0, $urandom_range(0, 19) != 0);
      end
      mrs_pkg::FC_READ_HOLDING: begin
        q = pick_q(125, c_hc);
        send_pdu(st, fc, pick_adr(c_hb, c_hc, q), q, -1, 0, $urandom_range(0, 19) != 0);
      end
      mrs_pkg::FC_READ_INPUT: begin
        q = pick_q(125, c_ic);
        send_pdu(st, fc, pick_adr(c_ib, c_ic, q), q, -1, 0, $urandom_range(0, 19) != 0);
      end
      mrs_pkg::FC_WRITE_COIL:
        send_pdu(st, fc, pick_adr(c_cb, c_cc, 1),
                 $urandom_range(0, 9) == 0 ? $urandom_range(0, 16'hFFFF) :
                 ($urandom_range(0, 1) ? 16'hFF00 : 0));
      mrs_pkg::FC_WRITE_REG:
        send_pdu(st, fc, pick_adr(c_hb, c_hc, 1), $urandom_range(0, 16'hFFFF));
      mrs_pkg::FC_WRITE_COILS: begin
        q = pick_q(512, c_cc);
        bc = q > 512 ? 8 : (q + 7) / 8;
        send_pdu(st, fc, pick_adr(c_cb, c_cc, q), q, bc, bc, $urandom_range(0, 19) != 0);
      end
      mrs_pkg::FC_WRITE_REGS: begin
        q = pick_q(120, c_hc);
        bc = q > 120 ? 8 : 2 * q;
        send_pdu(st, fc, pick_adr(c_hb, c_hc, q), q, bc, bc, $urandom_range(0, 19) != 0);
      end
      default: send_pdu(st, fc, $urandom, $urandom, $urandom_range(0, 6), $urandom);
    endcase
  endtask

  task automatic rand_mix(int count);
    int r;
    repeat (count) begin
      r = $urandom_range(0, 99);
      if (r < 8) push_local($urandom, $urandom);
      else if (r < 12) begin
        repeat ($urandom_range(1, 10)) push_req(mrs_pkg::CMD_BYTE, $urandom);
        close_frame();
      end else if (r < 14) push_req(CMD_UNUSED, $urandom);
      else rand_request();
    end
  endtask

  initial begin
    logic [7:0] f [$];
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    set_windows(1, 2, 0, STORE_DEPTH, 0, STORE_DEPTH, 0, STORE_DEPTH);
    // bytes before the first gap are ignored; unused command does nothing
    push_req(mrs_pkg::CMD_BYTE, 8'h01);
    push_req(CMD_UNUSED, 8'hA5);
    close_frame();
    // fill every store entry before anything reads it
    for (int i = 0; i < STORE_DEPTH; i++) push_local(i, $urandom);
    for (int a = 0; a < STORE_DEPTH; a += 120)
      send_pdu(1, mrs_pkg::FC_WRITE_REGS, a, a + 120 > 512 ? 32 : 120,
               a + 120 > 512 ? 64 : 240, a + 120 > 512 ? 64 : 240);
    send_pdu(1, mrs_pkg::FC_WRITE_COILS, 0, 512, 64, 64);

    send_pdu(1, mrs_pkg::FC_READ_COILS, 0, 1);
    send_pdu(1, mrs_pkg::FC_READ_DISCRETE, 511, 1);        // last entry of the window
    send_pdu(1, mrs_pkg::FC_READ_DISCRETE, 3, 13);         // partial coil byte
    send_pdu(1, mrs_pkg::FC_READ_COILS, 0, 960);           // legal quantity, beyond window
    send_pdu(1, mrs_pkg::FC_READ_COILS, 0, 961);
    send_pdu(1, mrs_pkg::FC_READ_HOLDING, 0, 0);
    send_pdu(1, mrs_pkg::FC_READ_HOLDING, 0, 125);         // longest reply
    send_pdu(1, mrs_pkg::FC_READ_INPUT, 511, 1);
    send_pdu(1, mrs_pkg::FC_READ_HOLDING, 500, 13);
    send_pdu(1, mrs_pkg::FC_READ_INPUT, 0, 126);
    send_pdu(1, mrs_pkg::FC_WRITE_COIL, 7, 16'hFF00);
    send_pdu(1, mrs_pkg::FC_WRITE_COIL, 8, 0);
    send_pdu(1, mrs_pkg::FC_WRITE_COIL, 9, 16'h1234);
    send_pdu(1, mrs_pkg::FC_WRITE_COIL, 512, 16'hFF00);
    send_pdu(1, mrs_pkg::FC_WRITE_REG, 511, 16'hFFFF);
    send_pdu(1, mrs_pkg::FC_WRITE_REG, 512, 0);
    send_pdu(1, mrs_pkg::FC_WRITE_COILS, 0, 9, 2, 2);
    send_pdu(1, mrs_pkg::FC_WRITE_COILS, 0, 9, 2, 3);      // byte count does not match
    send_pdu(1, mrs_pkg::FC_WRITE_COILS, 0, 1968, 246, 246);
    send_pdu(1, mrs_pkg::FC_WRITE_REGS, 0, 120, 240, 240);
    send_pdu(1, mrs_pkg::FC_WRITE_REGS, 0, 2, 3, 4);       // data shorter than announced
    send_pdu(1, 0, 0, 1);
    send_pdu(1, 7, 0, 1);
    send_pdu(1, 14, 0, 1);
    send_pdu(1, 17, 0, 1);
    send_pdu(1, 255, 0, 1);
    send_pdu(1, mrs_pkg::FC_READ_HOLDING, 0, 1, -1, 0, 1'b0);
    send_pdu(2, mrs_pkg::FC_READ_HOLDING, 0, 1);
    send_pdu(0, mrs_pkg::FC_READ_HOLDING, 0, 1);
    f = {8'h01, mrs_pkg::FC_READ_HOLDING, 8'h00, 8'h00};   // too short to run
    push_frame(f, 1'b1);
    f = {8'h01, mrs_pkg::FC_READ_HOLDING};                 // overflows the receive buffer
    repeat (296) f.push_back($urandom);
    push_frame(f, 1'b1);
    rand_mix(120);
    settle();

    set_windows(254, 0, 16'hFFFF, 1, 1000, 1023, 300, 0);
    send_pdu(254, mrs_pkg::FC_READ_COILS, 16'hFFFF, 1);
    send_pdu(254, mrs_pkg::FC_READ_HOLDING, 999, 1);
    send_pdu(254, mrs_pkg::FC_READ_HOLDING, 1511, 1);
    send_pdu(254, mrs_pkg::FC_READ_INPUT, 300, 1);
    rand_mix(80);
    settle();

    set_windows(8'h55, 255, 100, 300, 7, 64, 0, STORE_DEPTH);
    rand_mix(20);
    settle();

    set_windows($urandom_range(1, 254), $urandom_range(0, 12), $urandom_range(0, 400),
                $urandom_range(1, 600), $urandom_range(0, 400), $urandom_range(1, 600),
                $urandom_range(0, 400), $urandom_range(1, 600));
    // receiver holds off while long replies and further requests pile up
    hold_req = 1'b1;
    repeat (3) send_pdu(c_st, mrs_pkg::FC_READ_INPUT, c_ib,
                        eff_of(c_ic) < 125 ? eff_of(c_ic) : 125);
    rand_mix(150);
    settle();

    $display("covered %0d requests, %0d frames answered (%0d exceptions), %0d reply groups",
             n_req, n_replies, n_exc, n_groups);
    $display("four window settings incl. station/gap extremes, clipped and empty windows");
    if (reply_groups.size() > 0) report_mismatch("missing reply groups", 0, reply_groups.size());
    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
